// ===== src/gbsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbsw_pkg;

	localparam int OFFSET_WIDTH = 32;
	localparam int RES_W        = 32;
	localparam int SKIP_W       = 10;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] TAG_IMAGE   = 8'h2c;
	localparam logic [7:0] TAG_TRAILER = 8'h3b;
	localparam logic [7:0] TAG_EXT     = 8'h21;
	localparam logic [7:0] EXT_APP     = 8'hff;
	localparam logic [7:0] SIG_ALT_9   = 8'h39;
	localparam int         SIG_LEN     = 6;
	localparam int         VER_POS     = 4;
	localparam int         FLAGS_POS   = 10;
	localparam int         HDR_END_POS = 12;
	localparam int         MIN_LAST    = 15;
	localparam int         IMG_DESC_SKIP = 8;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_GCT,
		PH_TAG,
		PH_IMG_HDR,
		PH_IMG_FLAG,
		PH_LCT,
		PH_CODESIZE,
		PH_IMG_LEN,
		PH_IMG_DATA,
		PH_EXT_SUB,
		PH_EXT_LEN,
		PH_EXT_DATA,
		PH_DEAD
	} phase_t;

	typedef enum logic [1:0] {
		EV_SPAN    = 2'd0,
		EV_INSERT  = 2'd1,
		EV_NOT_GIF = 2'd2,
		EV_DONE    = 2'd3
	} event_kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		event_kind_t      event_kind;
		logic [RES_W-1:0] start_offset;
		logic [RES_W-1:0] end_offset;
		logic             final_result;
	} out_item_t;

	// up to two results from one byte, pushed into the queue together
	typedef struct packed {
		logic [1:0] count;
		out_item_t  r0;
		out_item_t  r1;
	} push_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h47;
			3'd1: v = 8'h49;
			3'd2: v = 8'h46;
			3'd3: v = 8'h38;
			3'd4: v = 8'h37;
			3'd5: v = 8'h61;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// color table size in bytes: 3 * 2^(n+1)
	function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] flags);
		logic [SKIP_W-1:0] v;
		v = SKIP_W'(3) << ({1'b0, flags[2:0]} + 4'd1);
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== src/gbsw_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbsw_parser
	import gbsw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	output push_t         push
);

	phase_t                  phase_q, phase_n;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_n;
	logic [SKIP_W-1:0]       skip_q, skip_n;
	logic                    sig_ok_q, sig_ok_n;
	logic [7:0]              subtype_q, subtype_n;
	logic [OFFSET_WIDTH-1:0] span_start_q, span_start_n;
	logic [OFFSET_WIDTH-1:0] insert_q, insert_n;
	logic                    insert_found_q, insert_found_n;

	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic [SKIP_W-1:0]       skip_dec;
	logic [7:0]              b;
	logic                    sig_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			pos_q          <= '0;
			skip_q         <= '0;
			sig_ok_q       <= 1'b1;
			subtype_q      <= '0;
			span_start_q   <= '0;
			insert_q       <= '0;
			insert_found_q <= 1'b0;
		end else begin
			phase_q        <= phase_n;
			pos_q          <= pos_n;
			skip_q         <= skip_n;
			sig_ok_q       <= sig_ok_n;
			subtype_q      <= subtype_n;
			span_start_q   <= span_start_n;
			insert_q       <= insert_n;
			insert_found_q <= insert_found_n;
		end
	end

	assign b         = item.byte_value;
	assign pos_inc   = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
	assign skip_dec  = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
	assign sig_match = (b == sig_byte(pos_q[2:0])) ||
		(pos_q == OFFSET_WIDTH'(VER_POS) && b == SIG_ALT_9);

	always_comb begin
		phase_n        = phase_q;
		pos_n          = pos_q;
		skip_n         = skip_q;
		sig_ok_n       = sig_ok_q;
		subtype_n      = subtype_q;
		span_start_n   = span_start_q;
		insert_n       = insert_q;
		insert_found_n = insert_found_q;
		push           = '0;

		if (step) begin
			if (phase_q == PH_HEADER) begin
				if (pos_q < OFFSET_WIDTH'(SIG_LEN)) begin
					if (!sig_match) begin
						sig_ok_n = 1'b0;
						phase_n  = PH_DEAD;
					end
				end else if (pos_q == OFFSET_WIDTH'(FLAGS_POS)) begin
					skip_n = b[7] ? table_bytes(b) : '0;
				end else if (pos_q >= OFFSET_WIDTH'(HDR_END_POS)) begin
					phase_n = (skip_q != '0) ? PH_GCT : PH_TAG;
				end
			end else if (!item.last_byte) begin
				unique case (phase_q)
					PH_GCT: begin
						skip_n = skip_dec;
						if (skip_dec == '0) phase_n = PH_TAG;
					end
					PH_TAG: begin
						if (b == TAG_TRAILER || b == TAG_IMAGE) begin
							if (!insert_found_q) begin
								insert_found_n = 1'b1;
								insert_n       = pos_q;
							end
							if (b == TAG_TRAILER) begin
								phase_n = PH_DEAD;
							end else begin
								skip_n  = SKIP_W'(IMG_DESC_SKIP);
								phase_n = PH_IMG_HDR;
							end
						end else if (b == TAG_EXT) begin
							phase_n = PH_EXT_SUB;
						end
					end
					PH_IMG_HDR: begin
						skip_n = skip_dec;
						if (skip_dec == '0) phase_n = PH_IMG_FLAG;
					end
					PH_IMG_FLAG: begin
						if (b[7]) begin
							skip_n  = table_bytes(b);
							phase_n = PH_LCT;
						end else begin
							phase_n = PH_CODESIZE;
						end
					end
					PH_LCT: begin
						skip_n = skip_dec;
						if (skip_dec == '0) phase_n = PH_CODESIZE;
					end
					PH_CODESIZE: phase_n = PH_IMG_LEN;
					PH_IMG_LEN: begin
						if (b == 8'd0) begin
							phase_n = PH_TAG;
						end else begin
							skip_n  = SKIP_W'(b);
							phase_n = PH_IMG_DATA;
						end
					end
					PH_IMG_DATA: begin
						skip_n = skip_dec;
						if (skip_dec == '0) phase_n = PH_IMG_LEN;
					end
					PH_EXT_SUB: begin
						subtype_n    = b;
						span_start_n = pos_inc;
						phase_n      = PH_EXT_LEN;
					end
					PH_EXT_LEN: begin
						if (b == 8'd0) begin
							if (subtype_q == EXT_APP) begin
								push.count           = 2'd1;
								push.r0.event_kind   = EV_SPAN;
								push.r0.start_offset = RES_W'(span_start_q);
								push.r0.end_offset   = RES_W'(pos_inc);
								push.r0.final_result = 1'b1;
							end
							phase_n = PH_TAG;
						end else begin
							skip_n  = SKIP_W'(b);
							phase_n = PH_EXT_DATA;
						end
					end
					PH_EXT_DATA: begin
						skip_n = skip_dec;
						if (skip_dec == '0) phase_n = PH_EXT_LEN;
					end
					default: ;
				endcase
			end

			if (item.last_byte) begin
				// signature check uses the value in effect after this byte
				if (!sig_ok_n || pos_q < OFFSET_WIDTH'(MIN_LAST)) begin
					push.count           = 2'd1;
					push.r0.event_kind   = EV_NOT_GIF;
					push.r0.final_result = 1'b1;
				end else if (insert_found_q) begin
					push.count           = 2'd2;
					push.r0.event_kind   = EV_INSERT;
					push.r0.start_offset = RES_W'(insert_q);
					push.r1.event_kind   = EV_DONE;
					push.r1.final_result = 1'b1;
				end else begin
					push.count           = 2'd1;
					push.r0.event_kind   = EV_DONE;
					push.r0.final_result = 1'b1;
				end
				// back to reset state for the next file
				phase_n        = PH_HEADER;
				pos_n          = '0;
				skip_n         = '0;
				sig_ok_n       = 1'b1;
				subtype_n      = '0;
				span_start_n   = '0;
				insert_n       = '0;
				insert_found_n = 1'b0;
			end else begin
				pos_n = pos_inc;
			end
		end
	end

	a_sig_dead: assert property (@(posedge clk) disable iff (!arst_n)
		!sig_ok_q |-> phase_q == PH_DEAD)
		else $error("signature failure left the dead phase");

	a_insert_order: assert property (@(posedge clk) disable iff (!arst_n)
		insert_found_q |-> insert_q <= pos_q)
		else $error("insert offset ahead of byte position");

	a_last_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> pos_q == '0 && phase_q == PH_HEADER)
		else $error("walker did not rewind after last byte");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q <= SKIP_W'(768))
		else $error("skip count out of range");

endmodule
`default_nettype wire

// ===== src/gbsw_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbsw_result_fifo
	import gbsw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       valid,
	input  wire logic  stall,
	output out_item_t  item
);

	out_item_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	logic [FIFO_AW-1:0] wr_ptr_1;

	assign valid    = (count_q != '0);
	assign pop      = valid && !stall;
	assign room     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign item     = mem_q[rd_ptr_q];
	assign wr_ptr_1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_ptr_1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("result pushed without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		FIFO_AW'(wr_ptr_q - rd_ptr_q) == FIFO_AW'(count_q))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== src/gif_block_structure_walker.sv =====
// Streaming GIF block walker. Bytes of one file enter on the byte channel, one
// item per cycle, the final byte flagged by last_byte; after it the walker is
// back in its reset state and the next byte starts a new file. Each byte is
// captured in an input register and walked from there once the result queue
// has room, and its results are registered in the queue. Results (application
// extension spans, then insert offset and done, or not-GIF) go through a
// four-entry queue; the byte channel stalls only while fewer than two entries
// are free, which happens when the result side stalls, since only the final
// byte of a file can produce two results. Sustained rate, unstalled: one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gif_block_structure_walker
	import gbsw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output out_item_t     result_item
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     room;
	logic     step;
	logic     accept;
	push_t    push;

	assign step       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= byte_item;
	end

	gbsw_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.push   (push)
	);

	gbsw_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (result_valid),
		.stall  (result_stall),
		.item   (result_item)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1)
		else $error("held byte dropped from input register");

	a_push_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> step)
		else $error("result produced without a byte step");

	a_last_results: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.last_byte |-> push.count != 2'd0)
		else $error("final byte produced no result");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

import gbsw_pkg::*;

class gif_walk_scoreboard;
	localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};

	string                    signature = "GIF87a";
	logic [OFFSET_WIDTH-1:0]  pos;
	phase_t                   phase;
	logic [SKIP_W-1:0]        skip;
	bit                       sig_ok;
	logic [7:0]               ext_label;
	logic [OFFSET_WIDTH-1:0]  span_start;
	logic [OFFSET_WIDTH-1:0]  insert_offset;
	bit                       insert_found;

	out_item_t expected_q[$];
	int        fail_count;

	function new();
		fail_count = 0;
		restart();
	endfunction

	function void restart();
		pos           = '0;
		phase         = PH_HEADER;
		skip          = '0;
		sig_ok        = 1'b1;
		ext_label     = '0;
		span_start    = '0;
		insert_offset = '0;
		insert_found  = 1'b0;
	endfunction

	function logic [SKIP_W-1:0] color_table_len(logic [7:0] flags);
		return SKIP_W'(3 * (2 << flags[2:0]));
	endfunction

	function void count_down(phase_t next);
		if (skip != 0)
			skip--;
		if (skip == 0)
			phase = next;
	endfunction

	function void add_result(event_kind_t kind, logic [OFFSET_WIDTH-1:0] s,
			logic [OFFSET_WIDTH-1:0] e, logic fin);
		out_item_t r;
		r.event_kind   = kind;
		r.start_offset = RES_W'(s);
		r.end_offset   = RES_W'(e);
		r.final_result = fin;
		expected_q.push_back(r);
	endfunction

	// walk one accepted byte and queue whatever results it causes
	function void note_byte(in_item_t it);
		logic [7:0] b;
		logic       last;
		b    = it.byte_value;
		last = it.last_byte;
		if (phase == PH_HEADER) begin
			if (pos < SIG_LEN) begin
				if (!(b == 8'(signature[pos[2:0]]) || (pos == VER_POS && b == SIG_ALT_9))) begin
					sig_ok = 1'b0;
					phase  = PH_DEAD;
				end
			end else if (pos == FLAGS_POS) begin
				skip = b[7] ? color_table_len(b) : '0;
			end else if (pos >= HDR_END_POS) begin
				phase = (skip != 0) ? PH_GCT : PH_TAG;
			end
		end else if (!last) begin
			case (phase)
				PH_GCT: count_down(PH_TAG);
				PH_TAG: begin
					if (b == TAG_TRAILER || b == TAG_IMAGE) begin
						if (!insert_found) begin
							insert_found  = 1'b1;
							insert_offset = pos;
						end
						if (b == TAG_TRAILER) begin
							phase = PH_DEAD;
						end else begin
							skip  = SKIP_W'(IMG_DESC_SKIP);
							phase = PH_IMG_HDR;
						end
					end else if (b == TAG_EXT) begin
						phase = PH_EXT_SUB;
					end
				end
				PH_IMG_HDR: count_down(PH_IMG_FLAG);
				PH_IMG_FLAG: begin
					if (b[7]) begin
						skip  = color_table_len(b);
						phase = PH_LCT;
					end else begin
						phase = PH_CODESIZE;
					end
				end
				PH_LCT: count_down(PH_CODESIZE);
				PH_CODESIZE: phase = PH_IMG_LEN;
				PH_IMG_LEN: begin
					if (b == 0) begin
						phase = PH_TAG;
					end else begin
						skip  = SKIP_W'(b);
						phase = PH_IMG_DATA;
					end
				end
				PH_IMG_DATA: count_down(PH_IMG_LEN);
				PH_EXT_SUB: begin
					ext_label  = b;
					span_start = (pos != POS_MAX) ? pos + 1'b1 : pos;
					phase      = PH_EXT_LEN;
				end
				PH_EXT_LEN: begin
					if (b == 0) begin
						if (ext_label == EXT_APP)
							add_result(EV_SPAN, span_start,
								(pos != POS_MAX) ? pos + 1'b1 : pos, 1'b1);
						phase = PH_TAG;
					end else begin
						skip  = SKIP_W'(b);
						phase = PH_EXT_DATA;
					end
				end
				PH_EXT_DATA: count_down(PH_EXT_LEN);
				default: ;
			endcase
		end

		if (last) begin
			if (!sig_ok || pos < MIN_LAST) begin
				add_result(EV_NOT_GIF, '0, '0, 1'b1);
			end else begin
				if (insert_found)
					add_result(EV_INSERT, insert_offset, '0, 1'b0);
				add_result(EV_DONE, '0, '0, 1'b1);
			end
			restart();
		end else if (pos != POS_MAX) begin
			pos++;
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t exp;
		if (expected_q.size() == 0) begin
			$error("unexpected result: kind %0d start %0h end %0h final %0b",
				got.event_kind, got.start_offset, got.end_offset, got.final_result);
			fail_count++;
			return;
		end
		exp = expected_q.pop_front();
		if (got.event_kind !== exp.event_kind) begin
			$error("event_kind: expected %0d, got %0d", exp.event_kind, got.event_kind);
			fail_count++;
		end
		if (got.start_offset !== exp.start_offset) begin
			$error("start_offset: expected %0h, got %0h", exp.start_offset, got.start_offset);
			fail_count++;
		end
		if (got.end_offset !== exp.end_offset) begin
			$error("end_offset: expected %0h, got %0h", exp.end_offset, got.end_offset);
			fail_count++;
		end
		if (got.final_result !== exp.final_result) begin
			$error("final_result: expected %0b, got %0b", exp.final_result, got.final_result);
			fail_count++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void flag_leftovers();
		if (expected_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_q.size());
			fail_count++;
		end
	endfunction
endclass

module testbench;
	localparam int RANDOM_ITEMS = 1450;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      byte_valid   = 1'b0;
	in_item_t  byte_item    = '0;
	logic      result_stall = 1'b0;
	logic      byte_stall;
	logic      result_valid;
	out_item_t result_item;

	gif_walk_scoreboard sb;
	logic [7:0]         file_q[$];
	int                 items_sent = 0;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	gif_block_structure_walker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	// result side: random stall, check each accepted item
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				sb.check_result(result_item);
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic send_byte(in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_byte(it);
		items_sent++;
	endtask

	task automatic send_file();
		in_item_t it;
		foreach (file_q[i]) begin
			it.byte_value = file_q[i];
			it.last_byte  = (i == file_q.size() - 1);
			send_byte(it);
		end
	endtask

	task automatic pause_until_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic void push_signature(logic [7:0] ver);
		file_q.push_back(8'h47);
		file_q.push_back(8'h49);
		file_q.push_back(8'h46);
		file_q.push_back(8'h38);
		file_q.push_back(ver);
		file_q.push_back(8'h61);
	endfunction

	function automatic void push_random(int n);
		repeat (n)
			file_q.push_back(8'($urandom));
	endfunction

	// mostly small color tables, now and then a large one
	function automatic logic [7:0] random_flags();
		logic [7:0] f;
		f = 8'($urandom);
		if (f[7] && $urandom_range(0, 15) != 0)
			f[2:0] = 3'($urandom_range(0, 2));
		return f;
	endfunction

	function automatic void push_table(logic [7:0] flags);
		if (flags[7])
			push_random(3 * (2 << flags[2:0]));
	endfunction

	function automatic void push_chain();
		int len;
		repeat ($urandom_range(0, 3)) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 255) : $urandom_range(1, 12);
			file_q.push_back(8'(len));
			push_random(len);
		end
		file_q.push_back(8'h00);
	endfunction

	function automatic void gen_file();
		logic [7:0] flags;
		logic [7:0] tag;
		int         sel;
		int         idx;
		file_q.delete();
		push_signature($urandom_range(0, 1) ? SIG_ALT_9 : 8'h37);
		push_random(4);
		flags = random_flags();
		file_q.push_back(flags);
		push_random(2);
		push_table(flags);
		repeat ($urandom_range(0, 5)) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				file_q.push_back(TAG_IMAGE);
				push_random(8);
				flags = random_flags();
				file_q.push_back(flags);
				push_table(flags);
				push_random(1);    // LZW code size
				push_chain();
			end else if (sel < 7) begin
				file_q.push_back(TAG_EXT);
				file_q.push_back(EXT_APP);
				push_chain();
			end else if (sel < 9) begin
				file_q.push_back(TAG_EXT);
				push_random(1);
				push_chain();
			end else begin
				do
					tag = 8'($urandom);
				while (tag == TAG_EXT || tag == TAG_IMAGE || tag == TAG_TRAILER);
				file_q.push_back(tag);
			end
		end
		// ending: none (last block runs to the end), trailer last, or trailer plus junk
		case ($urandom_range(0, 2))
			1: file_q.push_back(TAG_TRAILER);
			2: begin
				file_q.push_back(TAG_TRAILER);
				push_random($urandom_range(1, 5));
			end
			default: ;
		endcase
		// broken files: truncated, one byte hit, or plain noise
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			idx = $urandom_range(0, file_q.size() - 1);
			file_q = file_q[0:idx];
		end else if (sel < 17) begin
			idx = $urandom_range(0, file_q.size() - 1);
			file_q[idx] = 8'($urandom);
		end else if (sel < 22) begin
			file_q.delete();
			push_random($urandom_range(1, 30));
		end
	endfunction

	initial begin
		int target;
		sb = new();
		send_idle_pct = 9;
		recv_idle_pct = 61;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte file
		file_q.delete();
		file_q.push_back(8'h00);
		send_file();
		// bad signature, short
		file_q.delete();
		file_q.push_back(8'h47);
		file_q.push_back(8'h49);
		file_q.push_back(8'h46);
		file_q.push_back(8'h37);
		send_file();
		// no global table: empty app extension at 13, trailer at 16
		file_q.delete();
		push_signature(SIG_ALT_9);
		push_random(4);
		file_q.push_back(8'h00);
		file_q.push_back(8'hff);
		file_q.push_back(8'h00);
		file_q.push_back(TAG_EXT);
		file_q.push_back(EXT_APP);
		file_q.push_back(8'h00);
		file_q.push_back(TAG_TRAILER);
		file_q.push_back(8'hff);
		send_file();

		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				send_idle_pct = 61;
				recv_idle_pct = 9;
			end else if (p == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			target = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < target) begin
				gen_file();
				send_file();
			end
			// hold off until every queued result is out
			pause_until_drained();
		end

		repeat (8) @(posedge clk);
		sb.flag_leftovers();
		if (sb.fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
